// ----- rtl/ptdt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptdt_pkg
// Shared types and codes for the periodic task dispatch table.
// ----------------------------------------------------------------------------
package ptdt_pkg;

    localparam int NUM_SLOTS_DEF = 8;

    // Operation codes
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_CREATE   = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;
    localparam logic [1:0] OP_DISPATCH = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_NONE_RDY  = 3'd4;

    // One slot record as stored in the slot memory
    typedef struct packed {
        logic        present;
        logic        in_use;
        logic        ready;
        logic [15:0] countdown;
        logic [15:0] reload;
        logic [7:0]  rank;
        logic [7:0]  handle;
    } slot_t;

    // Contents of a slot that was never written since reset
    localparam slot_t SLOT_RESET = '{
        present:   1'b0,
        in_use:    1'b0,
        ready:     1'b0,
        countdown: 16'd0,
        reload:    16'd0,
        rank:      8'd255,
        handle:    8'd0
    };

endpackage

// ----- rtl/ptdt_slot_mem.sv -----
// ----------------------------------------------------------------------------
// ptdt_slot_mem
// Slot record memory: one write and one read port, registered read data.
// Per-entry valid bits make unwritten entries read as the reset record.
// ----------------------------------------------------------------------------
module ptdt_slot_mem
    import ptdt_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
    output slot_t                        rd_entry,
    input  logic                         wr_en,
    input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
    input  slot_t                        wr_entry
);

    slot_t                 slot_mem [NUM_SLOTS];
    slot_t                 rd_data_reg;
    logic                  rd_valid_reg;
    logic [NUM_SLOTS-1:0]  valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : SLOT_RESET;

endmodule

// ----- rtl/periodic_task_dispatch_table_core.sv -----
// ----------------------------------------------------------------------------
// periodic_task_dispatch_table_core
// Priority-ordered table of periodic tasks: tick, create, remove, dispatch.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake          | Payload
//  ----------+--------------------+---------------------------------------
//  command   | start, busy        | opcode, task_id, period, priority_req
//  result    | done (strobe)      | status, dispatched, dispatched_id
//
// Every transaction walks the slot memory once, one slot per cycle with the
// read of the next slot overlapping the write-back of the current one. A
// create that lands on a used slot adds the shift-down of the slots below
// it, one slot per cycle, followed by the final write of the new record.
// The single read port of the slot memory sets the pace of the walk.
// Reset is asynchronous and active low; the table reads as empty right after
// reset through per-slot valid bits, with no clearing pass.
// The result strobe lasts one cycle; the receiver cannot stall it, and busy
// drops in the same cycle so the next command may follow at once.
// ----------------------------------------------------------------------------
module periodic_task_dispatch_table_core
    import ptdt_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [7:0]  task_id,
    input  logic [15:0] period,
    input  logic [7:0]  priority_req,
    output logic        done,
    output logic [2:0]  status,
    output logic        dispatched,
    output logic [7:0]  dispatched_id
);

    localparam int              IDXW     = $clog2(NUM_SLOTS);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_SLOTS - 1);
    localparam logic [IDXW-1:0] IDX_ONE  = IDXW'(1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_FINISH = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_WRITE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Latched command
    logic [1:0]  op_reg,  op_next;
    logic [7:0]  id_reg,  id_next;
    logic [15:0] per_reg, per_next;
    logic [7:0]  pri_reg, pri_next;

    // Walk state
    logic [IDXW-1:0] proc_reg, proc_next;   // slot whose read data is on hand
    logic [IDXW-1:0] idx_reg,  idx_next;    // slot picked by the scan
    logic [IDXW-1:0] sh_reg,   sh_next;     // destination of the shift step
    logic            found_reg, found_next;
    logic            hit_use_reg, hit_use_next;   // picked slot in use
    logic            last_use_reg, last_use_next; // last slot in use
    slot_t           cap_reg,  cap_next;          // picked slot record

    // Result registers
    logic        done_reg, done_next;
    logic [2:0]  status_reg, status_next;
    logic        disp_reg, disp_next;
    logic [7:0]  disp_id_reg, disp_id_next;

    // Memory port
    logic            rd_en, wr_en;
    logic [IDXW-1:0] rd_addr, wr_addr;
    slot_t           rd_entry, wr_entry;

    slot_t ticked;
    slot_t new_entry;

    ptdt_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry)
    );

    // Count down a live timer; reload it and mark ready when it expires
    always_comb
    begin
        ticked = rd_entry;
        if (rd_entry.present && rd_entry.in_use && (rd_entry.countdown != 16'd0))
        begin
            ticked.countdown = rd_entry.countdown - 16'd1;
            if (rd_entry.countdown == 16'd1)
            begin
                ticked.countdown = rd_entry.reload;
                ticked.ready     = 1'b1;
            end
        end
    end

    // Record of a freshly created task; handle zero never becomes present
    always_comb
    begin
        new_entry.present   = (id_reg != 8'd0);
        new_entry.in_use    = 1'b1;
        new_entry.ready     = 1'b0;
        new_entry.countdown = per_reg;
        new_entry.reload    = per_reg;
        new_entry.rank      = pri_reg;
        new_entry.handle    = id_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        per_next      = per_reg;
        pri_next      = pri_reg;
        proc_next     = proc_reg;
        idx_next      = idx_reg;
        sh_next       = sh_reg;
        found_next    = found_reg;
        hit_use_next  = hit_use_reg;
        last_use_next = last_use_reg;
        cap_next      = cap_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        disp_next     = disp_reg;
        disp_id_next  = disp_id_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_entry      = rd_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // Capture the command and fetch slot zero
                    op_next    = opcode;
                    id_next    = task_id;
                    per_next   = period;
                    pri_next   = priority_req;
                    proc_next  = '0;
                    found_next = 1'b0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Advance the read while the current slot is examined
                if (proc_reg != LAST_IDX)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = proc_reg + IDX_ONE;
                    proc_next = proc_reg + IDX_ONE;
                end
                else
                begin
                    state_next = S_FINISH;
                end

                case (op_reg)
                    OP_TICK:
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = proc_reg;
                        wr_entry = ticked;
                    end
                    OP_CREATE:
                    begin
                        // First slot ranked strictly above the request
                        if (!found_reg && (rd_entry.rank > pri_reg))
                        begin
                            found_next   = 1'b1;
                            idx_next     = proc_reg;
                            hit_use_next = rd_entry.in_use;
                        end
                        if (proc_reg == LAST_IDX)
                        begin
                            last_use_next = rd_entry.in_use;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!found_reg && (rd_entry.handle == id_reg))
                        begin
                            found_next = 1'b1;
                            idx_next   = proc_reg;
                            cap_next   = rd_entry;
                        end
                    end
                    default:
                    begin
                        if (!found_reg && rd_entry.present && rd_entry.in_use
                            && rd_entry.ready)
                        begin
                            found_next = 1'b1;
                            idx_next   = proc_reg;
                            cap_next   = rd_entry;
                        end
                    end
                endcase
            end

            S_FINISH:
            begin
                done_next    = 1'b1;
                state_next   = S_IDLE;
                status_next  = ST_OK;
                disp_next    = 1'b0;
                disp_id_next = 8'd0;
                case (op_reg)
                    OP_TICK:
                    begin
                        status_next = ST_OK;
                    end
                    OP_CREATE:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (hit_use_reg && (idx_reg != LAST_IDX))
                        begin
                            // Open a hole: shift slots down, starting at the end
                            done_next  = 1'b0;
                            rd_en      = 1'b1;
                            rd_addr    = LAST_IDX - IDX_ONE;
                            sh_next    = LAST_IDX;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = idx_reg;
                            wr_entry    = new_entry;
                            status_next = (hit_use_reg && last_use_reg) ? ST_DROPPED
                                                                        : ST_OK;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = idx_reg;
                            wr_entry        = cap_reg;
                            wr_entry.in_use = 1'b0;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        if (found_reg)
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = idx_reg;
                            wr_entry       = cap_reg;
                            wr_entry.ready = 1'b0;
                            disp_next      = 1'b1;
                            disp_id_next   = cap_reg.handle;
                        end
                        else
                        begin
                            status_next = ST_NONE_RDY;
                        end
                    end
                endcase
            end

            S_SHIFT:
            begin
                // Move the slot above into the destination
                wr_en    = 1'b1;
                wr_addr  = sh_reg;
                wr_entry = rd_entry;
                if ((sh_reg - IDX_ONE) == idx_reg)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = sh_reg - IDX_ONE - IDX_ONE;
                    sh_next = sh_reg - IDX_ONE;
                end
            end

            S_WRITE:
            begin
                wr_en        = 1'b1;
                wr_addr      = idx_reg;
                wr_entry     = new_entry;
                done_next    = 1'b1;
                state_next   = S_IDLE;
                status_next  = last_use_reg ? ST_DROPPED : ST_OK;
                disp_next    = 1'b0;
                disp_id_next = 8'd0;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        per_reg      <= per_next;
        pri_reg      <= pri_next;
        proc_reg     <= proc_next;
        idx_reg      <= idx_next;
        sh_reg       <= sh_next;
        hit_use_reg  <= hit_use_next;
        last_use_reg <= last_use_next;
        cap_reg      <= cap_next;
        status_reg   <= status_next;
        disp_reg     <= disp_next;
        disp_id_reg  <= disp_id_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign dispatched    = disp_reg;
    assign dispatched_id = disp_id_reg;

    // An accepted command always occupies the block on the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // A dispatched task is always reported ok and carries a nonzero handle
    a_disp_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dispatched) |-> ((status == ST_OK) && (dispatched_id != 8'd0)))
        else $error("dispatch result inconsistent");

    // The shift never runs past the insertion slot
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (found_reg && (sh_reg > idx_reg)))
        else $error("shift walked past insertion slot");

    // Read and write never hit the same slot in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("slot read and write collide");

    // A result only follows a finishing state
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past((state_reg == S_FINISH) || (state_reg == S_WRITE)))
        else $error("result strobe without finishing state");

endmodule
